// ----- sv/birp_pkg.sv -----
// shared types and constants of the bulk in ring packetizer
package birp_pkg;

    // input operation codes
    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_SENT   = 3'd2;
    localparam logic [2:0] OP_LOCK   = 3'd3;
    localparam logic [2:0] OP_UNLOCK = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // result kinds, also used as command kinds in the queue
    localparam logic [1:0] KIND_COUNT = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_ZLP   = 2'd2;

    // send state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_ZLP  = 2'd2;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int COUNT_W     = 11;
    localparam int FRAME_W     = 8;
    localparam int ADDR_W_MAX  = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int CHUNK_CNT_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = 11'd2047;
    localparam logic [FRAME_W-1:0] FRAME_RESET  = 8'd5;

    typedef struct packed {
        logic [1:0]            kind;
        logic [ADDR_W_MAX-1:0] addr;
        logic [LEN_W-1:0]      size;
        logic [COUNT_W-1:0]    count;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [BYTE_W-1:0]  data;
        logic [LEN_W-1:0]   len;
        logic               last;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

// ----- sv/birp_ram.sv -----
// generic single write, single read ram with registered read data
module birp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/birp_queue.sv -----
// small command queue between the front and back parts
module birp_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (wr_en) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (rd_en) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    assign rd_data = slot_reg[rptr_reg];
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);

endmodule

// ----- sv/birp_front.sv -----
// front part: accepts operations, keeps ring and send bookkeeping, queues commands
module birp_front #(
    parameter int RING_DEPTH = 2048,
    parameter int MAX_PACKET = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [birp_pkg::FRAME_W-1:0]       cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         op,
    input  logic [birp_pkg::BYTE_W-1:0]        data_byte,
    input  logic                               push_last,
    input  logic                               push_first,
    input  logic                               configured,
    input  logic                               q_full,
    output logic                               q_wr_en,
    output birp_pkg::cmd_t                     q_wr_data,
    output logic                               ram_we,
    output logic [$clog2(RING_DEPTH)-1:0]      ram_waddr,
    output logic [birp_pkg::BYTE_W-1:0]        ram_wdata,
    input  logic                               chunk_done
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int PW = $clog2(RING_DEPTH + 1);

    logic [AW-1:0]                       push_idx_reg, push_idx_next;
    logic [PW-1:0]                       pop_idx_reg, pop_idx_next;
    logic [PW-1:0]                       span_reg, span_next;
    logic [1:0]                          state_reg, state_next;
    logic                                lock_reg, lock_next;
    logic [birp_pkg::FRAME_W-1:0]        frame_cnt_reg, frame_cnt_next;
    logic [birp_pkg::COUNT_W-1:0]        call_cnt_reg, call_cnt_next;
    logic [birp_pkg::FRAME_W-1:0]        interval_reg;
    logic [birp_pkg::CHUNK_CNT_W-1:0]    chunks_reg, chunks_next;

    logic                                accept;
    logic                                do_send;
    logic [PW-1:0]                       src_pop;
    logic [PW-1:0]                       src_span;
    logic [PW-1:0]                       chunk_size;
    logic [PW-1:0]                       span_after;
    logic [PW-1:0]                       pop_wrapped;
    logic [PW-1:0]                       push_ext;
    logic [PW-1:0]                       push_inc;
    logic [birp_pkg::COUNT_W-1:0]        cnt_base;
    logic [birp_pkg::COUNT_W-1:0]        cnt_inc;

    // pushes wait while a chunk is still being read out of the ring
    assign in_ready = !q_full && !((op == birp_pkg::OP_PUSH) && (chunks_reg != '0));
    assign accept   = in_valid && in_ready;

    assign pop_wrapped = (pop_idx_reg >= PW'(RING_DEPTH)) ? '0 : pop_idx_reg;
    assign push_ext    = PW'(push_idx_reg);
    assign push_inc    = push_ext + 1'b1;
    assign cnt_base    = push_first ? '0 : call_cnt_reg;
    assign cnt_inc     = (cnt_base < birp_pkg::COUNT_MAX) ? cnt_base + 1'b1 : cnt_base;

    always_comb begin
        push_idx_next  = push_idx_reg;
        pop_idx_next   = pop_idx_reg;
        span_next      = span_reg;
        state_next     = state_reg;
        lock_next      = lock_reg;
        frame_cnt_next = frame_cnt_reg;
        call_cnt_next  = call_cnt_reg;
        q_wr_en        = 1'b0;
        q_wr_data      = '0;
        ram_we         = 1'b0;
        ram_waddr      = push_idx_reg;
        ram_wdata      = data_byte;
        do_send        = 1'b0;
        src_pop        = pop_idx_reg;
        src_span       = span_reg;
        chunk_size     = '0;
        span_after     = '0;

        if (accept) begin
            case (op)
                birp_pkg::OP_PUSH: begin
                    ram_we = 1'b1;
                    if (push_inc == PW'(RING_DEPTH)) begin
                        push_idx_next = '0;
                        call_cnt_next = '0;
                    end else begin
                        push_idx_next = AW'(push_inc);
                        call_cnt_next = cnt_inc;
                    end
                    if (push_last) begin
                        q_wr_en         = 1'b1;
                        q_wr_data.kind  = birp_pkg::KIND_COUNT;
                        q_wr_data.count = (push_inc == PW'(RING_DEPTH)) ? '0 : cnt_inc;
                    end
                end
                birp_pkg::OP_TICK: begin
                    if (configured) begin
                        if (frame_cnt_reg == interval_reg) begin
                            frame_cnt_next = '0;
                            if (!lock_reg && (state_reg == birp_pkg::ST_IDLE)) begin
                                pop_idx_next = pop_wrapped;
                                if (pop_wrapped != push_ext) begin
                                    do_send  = 1'b1;
                                    src_pop  = pop_wrapped;
                                    src_span = (pop_wrapped > push_ext)
                                             ? PW'(RING_DEPTH) - pop_wrapped
                                             : push_ext - pop_wrapped;
                                end
                            end
                        end else begin
                            frame_cnt_next = frame_cnt_reg + 1'b1;
                        end
                    end
                end
                birp_pkg::OP_SENT: begin
                    if (state_reg == birp_pkg::ST_BUSY) begin
                        if (span_reg != '0) begin
                            do_send = 1'b1;
                        end else begin
                            state_next = birp_pkg::ST_IDLE;
                        end
                    end else if (state_reg == birp_pkg::ST_ZLP) begin
                        state_next     = birp_pkg::ST_IDLE;
                        q_wr_en        = 1'b1;
                        q_wr_data.kind = birp_pkg::KIND_ZLP;
                    end
                end
                birp_pkg::OP_LOCK: begin
                    lock_next = 1'b1;
                end
                birp_pkg::OP_UNLOCK: begin
                    lock_next = 1'b0;
                end
                birp_pkg::OP_CLEAR: begin
                    push_idx_next = '0;
                    pop_idx_next  = '0;
                    span_next     = '0;
                    state_next    = birp_pkg::ST_IDLE;
                    lock_next     = 1'b0;
                end
                default: begin
                end
            endcase
        end

        // next chunk of the current span
        if (do_send) begin
            chunk_size     = (src_span > PW'(MAX_PACKET)) ? PW'(MAX_PACKET) : src_span;
            span_after     = src_span - chunk_size;
            q_wr_en        = 1'b1;
            q_wr_data.kind = birp_pkg::KIND_DATA;
            q_wr_data.addr = birp_pkg::ADDR_W_MAX'(src_pop);
            q_wr_data.size = birp_pkg::LEN_W'(chunk_size);
            pop_idx_next   = src_pop + chunk_size;
            span_next      = span_after;
            state_next     = ((span_after == '0) && (chunk_size == PW'(MAX_PACKET)))
                           ? birp_pkg::ST_ZLP : birp_pkg::ST_BUSY;
        end
    end

    always_comb begin
        chunks_next = chunks_reg;
        if (do_send && !chunk_done) begin
            chunks_next = chunks_reg + 1'b1;
        end else if (!do_send && chunk_done) begin
            chunks_next = chunks_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            push_idx_reg  <= '0;
            pop_idx_reg   <= '0;
            span_reg      <= '0;
            state_reg     <= birp_pkg::ST_IDLE;
            lock_reg      <= 1'b0;
            frame_cnt_reg <= '0;
            call_cnt_reg  <= '0;
            interval_reg  <= birp_pkg::FRAME_RESET;
            chunks_reg    <= '0;
        end else begin
            push_idx_reg  <= push_idx_next;
            pop_idx_reg   <= pop_idx_next;
            span_reg      <= span_next;
            state_reg     <= state_next;
            lock_reg      <= lock_next;
            frame_cnt_reg <= frame_cnt_next;
            call_cnt_reg  <= call_cnt_next;
            chunks_reg    <= chunks_next;
            if (cfg_we) begin
                interval_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ----- sv/birp_back.sv -----
// back part: runs queued commands, streams chunk bytes from the ring into a two-entry output
module birp_back #(
    parameter int RING_DEPTH = 2048
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    output logic                          q_rd_en,
    input  birp_pkg::cmd_t                q_rd_data,
    output logic                          ram_re,
    output logic [$clog2(RING_DEPTH)-1:0] ram_raddr,
    input  logic [birp_pkg::BYTE_W-1:0]   ram_rdata,
    output logic                          chunk_done,
    output logic                          m_valid,
    input  logic                          m_ready,
    output birp_pkg::result_t             m_item
);

    localparam int AW = $clog2(RING_DEPTH);

    logic                         act_reg, act_next;
    logic [AW-1:0]                addr_reg, addr_next;
    logic [birp_pkg::LEN_W-1:0]   size_reg, size_next;
    logic [birp_pkg::LEN_W-1:0]   idx_reg, idx_next;

    logic                         pend_valid_reg;
    logic                         pend_ram_reg;
    birp_pkg::result_t            pend_item_reg;

    birp_pkg::result_t            ofifo_reg [2];
    logic                         wptr_reg, rptr_reg;
    logic [1:0]                   ocnt_reg, ocnt_next;

    logic                         issue;
    logic                         issue_ram;
    birp_pkg::result_t            issue_item;
    birp_pkg::result_t            fill_item;
    logic                         pop;
    logic [2:0]                   occ;
    logic                         room;
    logic                         last_byte;

    assign m_valid = (ocnt_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    // output entries plus the read in flight, after this cycle's pop
    assign occ     = 3'(ocnt_reg) + 3'(pend_valid_reg) - 3'(pop);
    assign room    = (occ < 3'd2);
    assign last_byte = (idx_reg == size_reg - 1'b1);

    always_comb begin
        act_next   = act_reg;
        addr_next  = addr_reg;
        size_next  = size_reg;
        idx_next   = idx_reg;
        issue      = 1'b0;
        issue_ram  = 1'b0;
        issue_item = '0;
        q_rd_en    = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = addr_reg + AW'(idx_reg);
        chunk_done = 1'b0;

        if (act_reg) begin
            if (room) begin
                issue           = 1'b1;
                issue_ram       = 1'b1;
                ram_re          = 1'b1;
                issue_item.kind = birp_pkg::KIND_DATA;
                issue_item.len  = size_reg;
                issue_item.last = last_byte;
                if (last_byte) begin
                    act_next   = 1'b0;
                    chunk_done = 1'b1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end else if (!q_empty) begin
            if (q_rd_data.kind == birp_pkg::KIND_DATA) begin
                q_rd_en   = 1'b1;
                act_next  = 1'b1;
                addr_next = AW'(q_rd_data.addr);
                size_next = q_rd_data.size;
                idx_next  = '0;
            end else if (room) begin
                q_rd_en          = 1'b1;
                issue            = 1'b1;
                issue_item.kind  = q_rd_data.kind;
                issue_item.last  = 1'b1;
                issue_item.count = (q_rd_data.kind == birp_pkg::KIND_COUNT)
                                 ? q_rd_data.count : '0;
            end
        end
    end

    always_comb begin
        fill_item      = pend_item_reg;
        fill_item.data = pend_ram_reg ? ram_rdata : '0;
        ocnt_next      = ocnt_reg + 2'(pend_valid_reg) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            wptr_reg       <= 1'b0;
            rptr_reg       <= 1'b0;
            ocnt_reg       <= 2'd0;
        end else begin
            act_reg        <= act_next;
            pend_valid_reg <= issue;
            ocnt_reg       <= ocnt_next;
            if (pend_valid_reg) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        size_reg      <= size_next;
        idx_reg       <= idx_next;
        pend_ram_reg  <= issue_ram;
        pend_item_reg <= issue_item;
        if (pend_valid_reg) begin
            ofifo_reg[wptr_reg] <= fill_item;
        end
    end

    assign m_item = ofifo_reg[rptr_reg];

    a_no_out_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ocnt_reg != 2'd3)
        else $error("output buffer overflow");

    a_read_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> ((32'(addr_reg) + 32'(idx_reg)) < 32'(RING_DEPTH)))
        else $error("chunk read beyond ring end");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_rd_en |-> !q_empty)
        else $error("command taken from empty queue");

    a_done_ends_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        chunk_done |=> (!act_reg && pend_valid_reg && pend_item_reg.last))
        else $error("chunk end not followed by last byte");

endmodule

// ----- sv/bulk_in_ring_packetizer_top.sv -----
// top level of the bulk in ring packetizer
// Application bytes are pushed into a ring of RING_DEPTH bytes and frame ticks
// trigger packetizing of the span up to the push index (or the ring end) into
// MAX_PACKET-byte chunks, with a zero-length packet after a final full chunk.
// The front part takes one operation per cycle while s_tready is high and
// updates all bookkeeping at once; operations that produce results leave a
// command in a four-entry queue. The back part drains that queue: a push
// count report or a zero-length packet becomes one result, and a chunk is
// loaded, then read through the registered ram read port one byte per cycle
// while the output buffer has room. A push waits at the input while any
// queued or active chunk has ring bytes still to read, and any operation
// waits while the command queue is full. Results leave through a two-entry
// output buffer, so a stalled master side does not stop new operations until
// the queue fills. There is no clearing pass after reset: ring entries never
// written are simply not read by a legal sequence of operations.
module bulk_in_ring_packetizer_top #(
    parameter int RING_DEPTH = 2048,
    parameter int MAX_PACKET = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: frame_interval
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // input transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte [7:0], push_first [8], configured [9], zero
    input  logic [2:0]  s_tuser,   // operation [2:0]
    input  logic        s_tlast,   // push_last
    // result transactions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte [7:0], packet_length [14:8],
                                   // pushed_count [25:15], zero
    output logic [1:0]  m_tuser,   // result_kind [1:0]
    output logic        m_tlast    // last_of_packet
);

    localparam int AW = $clog2(RING_DEPTH);

    // front to queue
    logic                         q_wr_en;
    birp_pkg::cmd_t               q_wr_data;
    logic                         q_full;
    // queue to back
    logic                         q_rd_en;
    birp_pkg::cmd_t               q_rd_data;
    logic                         q_empty;
    // ring ports
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [birp_pkg::BYTE_W-1:0]  ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [birp_pkg::BYTE_W-1:0]  ram_rdata;
    // back reports the last ring read of a chunk
    logic                         chunk_done;
    birp_pkg::result_t            m_item;

    birp_front #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_PACKET (MAX_PACKET)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .op         (s_tuser),
        .data_byte  (s_tdata[7:0]),
        .push_last  (s_tlast),
        .push_first (s_tdata[8]),
        .configured (s_tdata[9]),
        .q_full     (q_full),
        .q_wr_en    (q_wr_en),
        .q_wr_data  (q_wr_data),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .chunk_done (chunk_done)
    );

    // command queue decouples operation intake from packet streaming
    birp_queue #(
        .WIDTH ($bits(birp_pkg::cmd_t)),
        .DEPTH (birp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // ring storage, written by the front and read by the back
    birp_ram #(
        .WIDTH (birp_pkg::BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    birp_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_rd_en    (q_rd_en),
        .q_rd_data  (q_rd_data),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .chunk_done (chunk_done),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_item     (m_item)
    );

    // result packing
    assign m_tdata = {6'd0, m_item.count, m_item.len, m_item.data};
    assign m_tuser = m_item.kind;
    assign m_tlast = m_item.last;

endmodule

// ----- tb/bulk_in_ring_packetizer_top_tb.sv -----
// self-checking testbench of the bulk in ring packetizer: directed tests, then random traffic
module bulk_in_ring_packetizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH    = 2048;
    localparam int MAX_PACKET    = 64;
    localparam int SETTLE_CYCLES = 80;      // room for a full chunk to be loaded and read out
    localparam int FLUSH_CYCLES  = 120;
    localparam int CYCLE_LIMIT   = 60000000;
    localparam int REPORT_LIMIT  = 100;

    // operation codes the block must ignore
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;   // data_byte [7:0], push_first [8], configured [9], zero
    logic [2:0]  s_tuser   = 3'd0;    // operation [2:0]
    logic        s_tlast   = 1'b0;    // push_last
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;             // out_byte [7:0], packet_length [14:8],
                                      // pushed_count [25:15], zero
    logic [1:0]  m_tuser;             // result_kind [1:0]
    logic        m_tlast;             // last_of_packet

    bulk_in_ring_packetizer_top #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_PACKET (MAX_PACKET)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // packetizer state as the testbench predicts it
    logic [7:0]                   ring_mem [RING_DEPTH];
    int unsigned                  wr_idx;
    int unsigned                  rd_idx;
    int unsigned                  span_left;
    logic [1:0]                   tx_state;
    bit                           tx_locked;
    logic [birp_pkg::FRAME_W-1:0] sof_count;
    logic [birp_pkg::COUNT_W-1:0] call_bytes;
    logic [birp_pkg::FRAME_W-1:0] interval_reg;

    birp_pkg::result_t expected_results [$];
    int unsigned mismatch_count;
    int unsigned input_count;
    int unsigned counted_items;
    int unsigned result_count;
    int unsigned cycle_count;
    bit          src_gaps_on = 1'b1;

    // result sink pacing
    int unsigned sink_mode;
    int unsigned sink_left;
    int unsigned stall_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cycle limit reached with %0d results outstanding",
                     expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic void queue_result(logic [1:0] kind_v, logic [7:0] byte_v,
                                         logic [6:0] len_v, logic last_v,
                                         logic [10:0] count_v);
        birp_pkg::result_t r;
        r.kind  = kind_v;
        r.data  = byte_v;
        r.len   = len_v;
        r.last  = last_v;
        r.count = count_v;
        expected_results.push_back(r);
    endfunction

    // next chunk of the span, at most one full packet
    function automatic void emit_chunk();
        int unsigned size;
        logic [7:0]  b;
        size = (span_left > MAX_PACKET) ? MAX_PACKET : span_left;
        for (int unsigned i = 0; i < size; i++) begin
            b = (rd_idx + i < RING_DEPTH) ? ring_mem[rd_idx + i] : 8'd0;
            queue_result(birp_pkg::KIND_DATA, b, 7'(size), (i + 1 == size), '0);
        end
        rd_idx    += size;
        span_left -= size;
        tx_state = (span_left == 0 && size == MAX_PACKET) ? birp_pkg::ST_ZLP
                                                          : birp_pkg::ST_BUSY;
    endfunction

    function automatic void predict(logic [2:0] op, logic [7:0] dat, bit is_last,
                                    bit is_first, bit conf);
        case (op)
            birp_pkg::OP_PUSH: begin
                if (is_first)
                    call_bytes = '0;
                ring_mem[wr_idx] = dat;
                wr_idx++;
                if (call_bytes < birp_pkg::COUNT_MAX)
                    call_bytes++;
                if (wr_idx >= RING_DEPTH) begin
                    wr_idx     = 0;
                    call_bytes = '0;
                end
                if (is_last)
                    queue_result(birp_pkg::KIND_COUNT, '0, '0, 1'b1, call_bytes);
            end
            birp_pkg::OP_TICK: begin
                if (conf) begin
                    if (sof_count == interval_reg) begin
                        sof_count = '0;
                        if (!tx_locked && tx_state == birp_pkg::ST_IDLE) begin
                            if (rd_idx >= RING_DEPTH)
                                rd_idx = 0;
                            if (rd_idx != wr_idx) begin
                                // a wrapped push index limits the span to the ring end
                                span_left = (rd_idx > wr_idx) ? RING_DEPTH - rd_idx
                                                              : wr_idx - rd_idx;
                                emit_chunk();
                            end
                        end
                    end else begin
                        sof_count++;
                    end
                end
            end
            birp_pkg::OP_SENT: begin
                if (tx_state == birp_pkg::ST_BUSY) begin
                    if (span_left != 0)
                        emit_chunk();
                    else
                        tx_state = birp_pkg::ST_IDLE;
                end else if (tx_state == birp_pkg::ST_ZLP) begin
                    tx_state = birp_pkg::ST_IDLE;
                    queue_result(birp_pkg::KIND_ZLP, '0, '0, 1'b1, '0);
                end
            end
            birp_pkg::OP_LOCK:   tx_locked = 1'b1;
            birp_pkg::OP_UNLOCK: tx_locked = 1'b0;
            birp_pkg::OP_CLEAR: begin
                wr_idx    = 0;
                rd_idx    = 0;
                span_left = 0;
                tx_state  = birp_pkg::ST_IDLE;
                tx_locked = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic send_op(logic [2:0] op, logic [7:0] dat, bit is_last, bit is_first,
                           bit conf);
        int unsigned gap;
        int unsigned r;
        gap = 0;
        if (src_gaps_on) begin
            r = $urandom_range(0, 99);
            if (r >= 90)
                gap = $urandom_range(6, 25);
            else if (r >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, conf, is_first, dat};
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict(op, dat, is_last, is_first, conf);
        input_count++;
        if (op <= birp_pkg::OP_CLEAR && !(op == birp_pkg::OP_TICK && !conf))
            counted_items++;
    endtask

    // non-push operation, with the unused fields filled at random
    task automatic send_ctrl(logic [2:0] op, bit conf);
        send_op(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), conf);
    endtask

    // one push call; a count is also reported on the byte that wraps the ring
    task automatic push_call(int unsigned n, bit with_first);
        for (int unsigned i = 0; i < n; i++)
            send_op(birp_pkg::OP_PUSH, 8'($urandom_range(0, 255)),
                    (i + 1 == n) || (wr_idx == RING_DEPTH - 1),
                    with_first && (i == 0), 1'($urandom_range(0, 1)));
    endtask

    // configured ticks until exactly one transmit attempt has fired
    task automatic fire_attempt();
        while (sof_count != interval_reg)
            send_ctrl(birp_pkg::OP_TICK, 1'b1);
        send_ctrl(birp_pkg::OP_TICK, 1'b1);
    endtask

    task automatic drain_transfer();
        while (tx_state != birp_pkg::ST_IDLE)
            send_ctrl(birp_pkg::OP_SENT, 1'($urandom_range(0, 1)));
    endtask

    // register writes only with nothing in flight
    task automatic write_interval(logic [7:0] value);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        interval_reg = value;
    endtask

    // ---------------------------------------------------------------- result side

    always @(posedge aclk) begin
        if (sink_left == 0) begin
            sink_mode = $urandom_range(0, 2);
            sink_left = $urandom_range(50, 300);
        end else begin
            sink_left--;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (sink_mode == 1 && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else if (sink_mode == 2 && $urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(10, 40);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : check_result
        birp_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $error("unexpected result transaction: kind %0d byte %0d",
                           m_tuser, m_tdata[7:0]);
            end else begin
                want = expected_results.pop_front();
                check_field("result_kind", want.kind, m_tuser);
                check_field("out_byte", want.data, m_tdata[7:0]);
                check_field("packet_length", want.len, m_tdata[14:8]);
                check_field("last_of_packet", want.last, m_tlast);
                check_field("pushed_count", want.count, m_tdata[25:15]);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // every operation once, count continuation, ignored items, lock blocking a send
    task automatic test_basic_ops();
        send_op(birp_pkg::OP_PUSH, 8'h00, 1'b0, 1'b1, 1'b1);
        send_op(birp_pkg::OP_PUSH, 8'hFF, 1'b0, 1'b0, 1'b0);
        send_op(birp_pkg::OP_PUSH, 8'h5A, 1'b1, 1'b0, 1'b1);
        send_op(birp_pkg::OP_PUSH, 8'h81, 1'b1, 1'b0, 1'b0);    // no first flag: count goes on
        send_ctrl(OP_RSVD6, 1'b1);
        send_ctrl(OP_RSVD7, 1'b1);
        send_ctrl(birp_pkg::OP_SENT, 1'b1);                     // idle, nothing to do
        send_ctrl(birp_pkg::OP_TICK, 1'b0);                     // not configured, not counted
        send_ctrl(birp_pkg::OP_LOCK, 1'b1);
        fire_attempt();                                         // blocked by the lock
        send_ctrl(birp_pkg::OP_UNLOCK, 1'b0);
        fire_attempt();
        send_ctrl(birp_pkg::OP_SENT, 1'b1);                     // busy with nothing left
        send_ctrl(birp_pkg::OP_CLEAR, 1'b1);
    endtask

    // spans of one and two full packets end with a zero-length packet, a span one byte longer does not
    task automatic test_zero_length_packet();
        push_call(MAX_PACKET * 2, 1'b1);
        fire_attempt();
        send_ctrl(birp_pkg::OP_SENT, 1'b1);
        send_ctrl(birp_pkg::OP_SENT, 1'b0);
        send_ctrl(birp_pkg::OP_SENT, 1'b1);                     // idle again, ignored
        push_call(MAX_PACKET, 1'b1);
        fire_attempt();
        drain_transfer();
        push_call(MAX_PACKET + 1, 1'b1);
        fire_attempt();
        drain_transfer();
    endtask

    task automatic test_interval_settings();
        write_interval(8'd255);
        push_call(2, 1'b1);
        fire_attempt();
        drain_transfer();
        write_interval(8'd0);
        push_call(3, 1'b1);
        fire_attempt();
        drain_transfer();
        // lowered below the running counter: it wraps through 255 first
        write_interval(8'd20);
        push_call(5, 1'b1);
        repeat (10) send_ctrl(birp_pkg::OP_TICK, 1'b1);
        write_interval(8'd3);
        fire_attempt();
        drain_transfer();
    endtask

    task automatic test_ring_wrap_and_saturation();
        write_interval(8'd0);
        send_ctrl(birp_pkg::OP_CLEAR, 1'b0);
        push_call(1000, 1'b1);
        fire_attempt();
        drain_transfer();
        // push index wraps behind the pop index, count restarts at the wrap
        push_call(1100, 1'b1);
        fire_attempt();                                         // span up to the ring end
        drain_transfer();
        fire_attempt();                                         // pop index back at zero
        drain_transfer();
        // clear keeps the count, so it runs into saturation
        send_ctrl(birp_pkg::OP_CLEAR, 1'b1);
        push_call(2000, 1'b0);
        send_ctrl(birp_pkg::OP_CLEAR, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned phase_start;
        int unsigned r;
        int unsigned n;
        logic [7:0]  value;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: value = 8'd1;
                1: value = 8'd0;
                2: value = 8'd3;
                default: value = 8'($urandom_range(0, 6));
            endcase
            write_interval(value);
            phase_start = counted_items;
            while (counted_items - phase_start < 93) begin
                src_gaps_on = ($urandom_range(0, 3) != 0);
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    // push call, mostly well formed
                    n = $urandom_range(0, 99);
                    if (n < 70)
                        n = $urandom_range(1, 16);
                    else if (n < 85)
                        n = $urandom_range(17, 70);
                    else if (n < 95)
                        n = MAX_PACKET;
                    else
                        n = MAX_PACKET * 2;
                    for (int unsigned i = 0; i < n; i++)
                        send_op(birp_pkg::OP_PUSH, 8'($urandom_range(0, 255)),
                                (i + 1 == n) ? ($urandom_range(0, 9) != 0)
                                             : ($urandom_range(0, 24) == 0),
                                (i == 0) && ($urandom_range(0, 9) != 0),
                                1'($urandom_range(0, 1)));
                end else if (r < 62) begin
                    repeat ($urandom_range(1, interval_reg + 3))
                        send_ctrl(birp_pkg::OP_TICK, $urandom_range(0, 7) != 0);
                end else if (r < 80) begin
                    repeat ($urandom_range(1, 3))
                        send_ctrl(birp_pkg::OP_SENT, 1'($urandom_range(0, 1)));
                end else if (r < 86) begin
                    send_ctrl(birp_pkg::OP_LOCK, 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, interval_reg + 2))
                        send_ctrl(birp_pkg::OP_TICK, 1'b1);
                    if ($urandom_range(0, 4) != 0)
                        send_ctrl(birp_pkg::OP_UNLOCK, 1'($urandom_range(0, 1)));
                end else if (r < 89) begin
                    send_ctrl(birp_pkg::OP_CLEAR, 1'($urandom_range(0, 1)));
                end else begin
                    repeat ($urandom_range(1, 3))
                        send_op(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        wr_idx       = 0;
        rd_idx       = 0;
        span_left    = 0;
        tx_state     = birp_pkg::ST_IDLE;
        tx_locked    = 1'b0;
        sof_count    = '0;
        call_bytes   = '0;
        interval_reg = birp_pkg::FRAME_RESET;
        foreach (ring_mem[i])
            ring_mem[i] = 8'd0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_basic_ops();
        test_zero_length_packet();
        test_interval_settings();
        test_ring_wrap_and_saturation();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (FLUSH_CYCLES) @(posedge aclk);

        $display("%0d input transactions sent, %0d result transactions checked",
                 input_count, result_count);
        $display("ring wrap, count saturation, zero-length packets, intervals 0 to 255");
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- bulk_in_ring_packetizer_top.f -----
sv/birp_pkg.sv
sv/birp_ram.sv
sv/birp_queue.sv
sv/birp_front.sv
sv/birp_back.sv
sv/bulk_in_ring_packetizer_top.sv
tb/bulk_in_ring_packetizer_top_tb.sv
